// ===== hdl/cascaded_pi_voltage_current_core_macros.svh =====
// Assertion macros for the cascaded PI voltage/current core.
// Used by the port checker; no other dependencies.
`ifndef CASCADED_PI_VOLTAGE_CURRENT_CORE_MACROS_SVH
`define CASCADED_PI_VOLTAGE_CURRENT_CORE_MACROS_SVH

// same-cycle implication
`define CPVC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cpvc: assertion failed");

// next-cycle implication
`define CPVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cpvc: assertion failed");

`endif

// ===== hdl/cpvc_pkg.sv =====
// Package for the cascaded PI voltage/current core.
// Field widths, register codes, micro-op codes and the microprogram ROM.
package cpvc_pkg;

   localparam int SAMPLE_BITS_DEF    = 10;
   localparam int GAIN_FRAC_BITS_DEF = 16;
   localparam int INTEG_WIDTH_DEF    = 40;

   localparam int FIELD_W  = 10;   // converter code fields
   localparam int GAIN_W   = 24;   // gain registers, signed Q8.x
   localparam int DUTY_W   = 17;   // Q0.16, full scale inclusive
   localparam int CT_W     = 11;   // current reference field
   localparam int CSR_IDX_W = 2;
   localparam int PC_W     = 4;

   localparam logic signed [GAIN_W-1:0] VOLT_PROP_RST  = -24'sd42337;
   localparam logic signed [GAIN_W-1:0] VOLT_INTEG_RST = -24'sd454;
   localparam logic signed [GAIN_W-1:0] CURR_PROP_RST  = 24'sd65536;
   localparam logic signed [GAIN_W-1:0] CURR_INTEG_RST = 24'sd3277;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLT_PROP  = 2'd0,
      CSR_VOLT_INTEG = 2'd1,
      CSR_CURR_PROP  = 2'd2,
      CSR_CURR_INTEG = 2'd3
   } csr_reg_type;

   typedef enum logic [3:0] {
      UOP_ERR_V,    // err = vref - vmeas
      UOP_MUL_KP,   // prod = kp * err
      UOP_MUL_KI,   // p = prod, prod = ki * err
      UOP_ACC,      // integrator += prod, saturating
      UOP_SUM,      // sum = p + clamped integrator
      UOP_CLAMP,    // q16 = to_q16(clamp(sum))
      UOP_IREF,     // current reference from outer fraction
      UOP_ERR_C,    // err = iref - imeas
      UOP_DONE      // hand result to output register
   } uop_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_ALWAYS,
      JMP_IF_INNER
   } jump_type;

   typedef struct packed {
      uop_type          op;
      jump_type         jump;
      logic [PC_W-1:0]  target;
   } ucode_type;

   // sequencer -> datapath
   typedef struct packed {
      logic    start;     // item accepted, latch samples
      logic    run;       // execute op this cycle
      uop_type op;
      logic    inner;     // 0: voltage loop, 1: current loop
      logic    out_load;  // load result registers
   } ctrl_type;

   // Microprogram. Steps 1..5 form the PI body shared by both loops.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{op: UOP_DONE, jump: JMP_NONE, target: '0};
      case (pc)
         4'd0: w = '{op: UOP_ERR_V,  jump: JMP_NONE,     target: 4'd0};
         4'd1: w = '{op: UOP_MUL_KP, jump: JMP_NONE,     target: 4'd0};
         4'd2: w = '{op: UOP_MUL_KI, jump: JMP_NONE,     target: 4'd0};
         4'd3: w = '{op: UOP_ACC,    jump: JMP_NONE,     target: 4'd0};
         4'd4: w = '{op: UOP_SUM,    jump: JMP_NONE,     target: 4'd0};
         4'd5: w = '{op: UOP_CLAMP,  jump: JMP_IF_INNER, target: 4'd8};
         4'd6: w = '{op: UOP_IREF,   jump: JMP_NONE,     target: 4'd0};
         4'd7: w = '{op: UOP_ERR_C,  jump: JMP_ALWAYS,   target: 4'd1};
         4'd8: w = '{op: UOP_DONE,   jump: JMP_NONE,     target: 4'd0};
         default: w = '{op: UOP_DONE, jump: JMP_NONE, target: 4'd0};
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/cpvc_ifs.sv =====
// Channel interfaces for the cascaded PI core: request, response, register write.
// Depends on cpvc_pkg for field widths.
interface cpvc_req_if import cpvc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] volt_target;
   logic [FIELD_W-1:0] volt_sample;
   logic [FIELD_W-1:0] curr_sample;
   modport source (output valid, volt_target, volt_sample, curr_sample, input ready);
   modport sink   (input valid, volt_target, volt_sample, curr_sample, output ready);
endinterface

interface cpvc_rsp_if import cpvc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty;
   logic [CT_W-1:0]   curr_target;
   modport source (output valid, duty, curr_target, input ready);
   modport sink   (input valid, duty, curr_target, output ready);
endinterface

interface cpvc_csr_if import cpvc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [GAIN_W-1:0]    wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== hdl/cpvc_seq.sv =====
// Microcode sequencer: step counter, ROM fetch, jumps and item handshake.
// Depends on cpvc_pkg (ucode_rom, ctrl_type).
module cpvc_seq import cpvc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output ctrl_type ctrl
);

   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            inner_ff, inner_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            accept;
   logic            out_load;
   ucode_type       word;

   assign word   = ucode_rom(pc_ff);
   assign accept = req_valid && !busy_ff;

   always_comb begin
      busy_in  = busy_ff;
      pc_in    = pc_ff;
      inner_in = inner_ff;
      out_load = 1'b0;
      if (busy_ff) begin
         if (word.op == UOP_DONE) begin
            // wait here while the previous result is still held
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               busy_in  = 1'b0;
            end
         end else begin
            case (word.jump)
               JMP_ALWAYS:   pc_in = word.target;
               JMP_IF_INNER: pc_in = inner_ff ? word.target : pc_ff + 1'b1;
               default:      pc_in = pc_ff + 1'b1;
            endcase
            if (word.op == UOP_IREF)
               inner_in = 1'b1;
         end
      end
      if (accept) begin
         busy_in  = 1'b1;
         pc_in    = '0;
         inner_in = 1'b0;
      end
      if (out_load)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         inner_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         inner_ff     <= inner_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready     = !busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign ctrl.start    = accept;
   assign ctrl.run      = busy_ff && (word.op != UOP_DONE);
   assign ctrl.op       = word.op;
   assign ctrl.inner    = inner_ff;
   assign ctrl.out_load = out_load;

endmodule

// ===== hdl/cpvc_dp.sv =====
// Datapath: shared multiplier, saturating integrators, clamp and Q0.16 rounding.
// Depends on cpvc_pkg (ctrl_type, uop_type, widths).
module cpvc_dp import cpvc_pkg::*; #(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
   parameter int INTEG_WIDTH    = INTEG_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_type                 ctrl,
   input  logic signed [GAIN_W-1:0] volt_prop_gain,
   input  logic signed [GAIN_W-1:0] volt_integ_gain,
   input  logic signed [GAIN_W-1:0] curr_prop_gain,
   input  logic signed [GAIN_W-1:0] curr_integ_gain,
   input  logic [FIELD_W-1:0]       volt_target,
   input  logic [FIELD_W-1:0]       volt_sample,
   input  logic [FIELD_W-1:0]       curr_sample,
   output logic [DUTY_W-1:0]        duty,
   output logic [CT_W-1:0]          curr_target
);

   localparam int SB    = SAMPLE_BITS;
   localparam int GF    = GAIN_FRAC_BITS;
   localparam int IW    = INTEG_WIDTH;
   localparam int ERR_W = SB + 2;
   localparam int PW    = GAIN_W + ERR_W;
   localparam int ASW   = ((IW > PW) ? IW : PW) + 1;   // saturating add
   localparam int SW    = ((IW > 44) ? IW : 44) + 1;   // P + I
   localparam int IR_W  = SB + 17;

   localparam logic signed [ASW-1:0] IMAX = {{(ASW-IW+1){1'b0}}, {(IW-1){1'b1}}};
   localparam logic signed [ASW-1:0] IMIN = {{(ASW-IW+1){1'b1}}, {(IW-1){1'b0}}};
   localparam logic signed [SW-1:0]  LIM_P = {{(SW-43){1'b0}}, 1'b1, {42{1'b0}}};
   localparam logic signed [SW-1:0]  LIM_N = -LIM_P;
   localparam logic signed [SW-1:0]  ONE_S = {{(SW-GF-1){1'b0}}, 1'b1, {GF{1'b0}}};

   logic [SB-1:0]           vt_ff, vs_ff, cs_ff;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [PW-1:0]    p_ff, p_in;
   logic signed [IW-1:0]    volt_integ_ff, volt_integ_in;
   logic signed [IW-1:0]    curr_integ_ff, curr_integ_in;
   logic signed [SW-1:0]    sum_ff, sum_in;
   logic [DUTY_W-1:0]       q16_ff, q16_in;
   logic [SB:0]             iref_ff, iref_in;
   logic [DUTY_W-1:0]       duty_ff;
   logic [CT_W-1:0]         ct_ff;

   logic signed [GAIN_W-1:0] mul_gain;
   logic signed [PW-1:0]     mul_out;
   logic signed [IW-1:0]     integ_sel;
   logic signed [ASW-1:0]    acc_sum;
   logic signed [IW-1:0]     acc_sat;
   logic signed [SW-1:0]     integ_ext, integ_clip, sum_c;
   logic [GF:0]              q_c;
   logic [DUTY_W-1:0]        q16_c;
   logic [IR_W-1:0]          ir_t;
   logic [SB:0]              iref_c;
   logic signed [ERR_W-1:0]  diff_v, diff_c;

   // shared multiplier
   always_comb begin
      if (ctrl.op == UOP_MUL_KP)
         mul_gain = ctrl.inner ? curr_prop_gain : volt_prop_gain;
      else
         mul_gain = ctrl.inner ? curr_integ_gain : volt_integ_gain;
   end
   assign mul_out = mul_gain * err_ff;

   // integrator update with saturation at the register width
   assign integ_sel = ctrl.inner ? curr_integ_ff : volt_integ_ff;
   assign acc_sum   = ASW'(integ_sel) + ASW'(prod_ff);
   always_comb begin
      if (acc_sum > IMAX)
         acc_sat = IMAX[IW-1:0];
      else if (acc_sum < IMIN)
         acc_sat = IMIN[IW-1:0];
      else
         acc_sat = acc_sum[IW-1:0];
   end

   // P + I with the integrator held to +-2^42
   assign integ_ext = SW'(integ_sel);
   always_comb begin
      if (integ_ext > LIM_P)
         integ_clip = LIM_P;
      else if (integ_ext < LIM_N)
         integ_clip = LIM_N;
      else
         integ_clip = integ_ext;
   end
   assign sum_c = SW'(p_ff) + integ_clip;

   // loop output clamp to [0, 1]
   always_comb begin
      if (sum_ff > ONE_S)
         q_c = ONE_S[GF:0];
      else if (sum_ff < 0)
         q_c = '0;
      else
         q_c = sum_ff[GF:0];
   end

   generate
      if (GF > 16) begin : g_round
         localparam logic [GF:0] HALF = (GF+1)'(1) << (GF - 17);
         logic [GF:0] q_r;
         assign q_r   = q_c + HALF;
         assign q16_c = DUTY_W'(q_r >> (GF - 16));
      end else begin : g_shift
         assign q16_c = DUTY_W'(q_c) << (16 - GF);
      end
   endgenerate

   // fraction to converter codes, round half up
   assign ir_t   = (IR_W'(q16_ff) << SB) + (IR_W'(1) << 15);
   assign iref_c = ir_t[IR_W-1:16];

   assign diff_v = $signed({2'b00, vt_ff}) - $signed({2'b00, vs_ff});
   assign diff_c = $signed({1'b0, iref_ff}) - $signed({2'b00, cs_ff});

   always_comb begin
      err_in        = err_ff;
      prod_in       = prod_ff;
      p_in          = p_ff;
      volt_integ_in = volt_integ_ff;
      curr_integ_in = curr_integ_ff;
      sum_in        = sum_ff;
      q16_in        = q16_ff;
      iref_in       = iref_ff;
      if (ctrl.run) begin
         case (ctrl.op)
            UOP_ERR_V:  err_in = diff_v;
            UOP_MUL_KP: prod_in = mul_out;
            UOP_MUL_KI: begin
               p_in    = prod_ff;
               prod_in = mul_out;
            end
            UOP_ACC: begin
               if (ctrl.inner)
                  curr_integ_in = acc_sat;
               else
                  volt_integ_in = acc_sat;
            end
            UOP_SUM:    sum_in = sum_c;
            UOP_CLAMP:  q16_in = q16_c;
            UOP_IREF:   iref_in = iref_c;
            UOP_ERR_C:  err_in = diff_c;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volt_integ_ff <= '0;
         curr_integ_ff <= '0;
      end else begin
         volt_integ_ff <= volt_integ_in;
         curr_integ_ff <= curr_integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         vt_ff <= SB'(volt_target);
         vs_ff <= SB'(volt_sample);
         cs_ff <= SB'(curr_sample);
      end
      err_ff  <= err_in;
      prod_ff <= prod_in;
      p_ff    <= p_in;
      sum_ff  <= sum_in;
      q16_ff  <= q16_in;
      iref_ff <= iref_in;
      if (ctrl.out_load) begin
         duty_ff <= q16_ff;
         ct_ff   <= CT_W'(iref_ff);
      end
   end

   assign duty        = duty_ff;
   assign curr_target = ct_ff;

endmodule

// ===== hdl/cascaded_pi_voltage_current_core.sv =====
// Top level of the cascaded PI voltage/current controller.
// Depends on cpvc_pkg, cpvc_ifs (channels), cpvc_seq and cpvc_dp.
//
//   channel  | dir | payload                               | role
//   ---------+-----+---------------------------------------+------------------------
//   req_port | in  | volt_target, volt_sample, curr_sample | one control period
//   rsp_port | out | duty, curr_target                     | loop outputs
//   csr_port | in  | reg_index, wdata                      | gain register writes
//
// From acceptance to a valid result an item runs through 14 microprogram
// steps (13 arithmetic steps and the final load), each driving one register
// stage of the datapath, with the single 24 x (SAMPLE_BITS+2) multiplier used
// twice per loop. One item is in work at a time; the next is taken the cycle
// after the result is loaded. A held result does not block acceptance; only the
// final step waits for it. Reset (synchronous) clears both integrators, restores
// the default gains, empties the sequencer and clears the result valid flag; the
// output data registers keep their value. Gain writes are always taken.

module cascaded_pi_voltage_current_core import cpvc_pkg::*; #(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
   parameter int INTEG_WIDTH    = INTEG_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   cpvc_req_if.sink  req_port,
   cpvc_rsp_if.source rsp_port,
   cpvc_csr_if.sink  csr_port
);

   // gain registers, signed Q8.x
   logic signed [GAIN_W-1:0] volt_prop_ff,  volt_prop_in;
   logic signed [GAIN_W-1:0] volt_integ_ff, volt_integ_in;
   logic signed [GAIN_W-1:0] curr_prop_ff,  curr_prop_in;
   logic signed [GAIN_W-1:0] curr_integ_ff, curr_integ_in;
   logic                     csr_write;
   ctrl_type                 ctrl;

   assign csr_port.ready = 1'b1;
   assign csr_write      = csr_port.valid && csr_port.ready;

   always_comb begin
      volt_prop_in  = volt_prop_ff;
      volt_integ_in = volt_integ_ff;
      curr_prop_in  = curr_prop_ff;
      curr_integ_in = curr_integ_ff;
      if (csr_write) begin
         case (csr_reg_type'(csr_port.reg_index))
            CSR_VOLT_PROP:  volt_prop_in  = csr_port.wdata;
            CSR_VOLT_INTEG: volt_integ_in = csr_port.wdata;
            CSR_CURR_PROP:  curr_prop_in  = csr_port.wdata;
            CSR_CURR_INTEG: curr_integ_in = csr_port.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volt_prop_ff  <= VOLT_PROP_RST;
         volt_integ_ff <= VOLT_INTEG_RST;
         curr_prop_ff  <= CURR_PROP_RST;
         curr_integ_ff <= CURR_INTEG_RST;
      end else begin
         volt_prop_ff  <= volt_prop_in;
         volt_integ_ff <= volt_integ_in;
         curr_prop_ff  <= curr_prop_in;
         curr_integ_ff <= curr_integ_in;
      end
   end

   // step counter, ROM and handshakes
   cpvc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .ctrl      (ctrl)
   );

   // arithmetic, integrators and result registers
   cpvc_dp #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .INTEG_WIDTH    (INTEG_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .volt_prop_gain  (volt_prop_ff),
      .volt_integ_gain (volt_integ_ff),
      .curr_prop_gain  (curr_prop_ff),
      .curr_integ_gain (curr_integ_ff),
      .volt_target     (req_port.volt_target),
      .volt_sample     (req_port.volt_sample),
      .curr_sample     (req_port.curr_sample),
      .duty            (rsp_port.duty),
      .curr_target     (rsp_port.curr_target)
   );

endmodule

// ===== hdl/cpvc_chk.sv =====
// Port-level checker for the cascaded PI core, bound to the top level.
// Depends on cpvc_pkg and the assertion macros header.
`include "cascaded_pi_voltage_current_core_macros.svh"

module cpvc_chk import cpvc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DUTY_W-1:0] rsp_duty,
   input logic [CT_W-1:0]   rsp_curr_target,
   input logic              csr_valid,
   input logic              csr_ready
);

   // one item in work: no second acceptance straight after the first
   `CPVC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // a result never appears the cycle after an item is taken
   `CPVC_ASSERT_NEXT(a_no_early_result, clock, reset, req_valid && req_ready, !$rose(rsp_valid))
   // a stalled result holds
   `CPVC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_duty) && $stable(rsp_curr_target))
   // gain writes are never refused
   `CPVC_ASSERT_SAME(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind cascaded_pi_voltage_current_core cpvc_chk u_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_port.valid),
   .req_ready       (req_port.ready),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_duty        (rsp_port.duty),
   .rsp_curr_target (rsp_port.curr_target),
   .csr_valid       (csr_port.valid),
   .csr_ready       (csr_port.ready)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for cascaded_pi_voltage_current_core: predicts each control period
// and checks duty and current reference in order. Depends on cpvc_pkg, cpvc_ifs and the core.
module testbench import cpvc_pkg::*; ();

   localparam int     INTEG_W       = INTEG_WIDTH_DEF;
   localparam longint ACC_MAX       = (64'sd1 <<< (INTEG_W - 1)) - 1;
   localparam longint ACC_MIN       = -ACC_MAX - 1;
   localparam longint SUM_LIMIT     = 64'sd1 <<< 42;
   localparam longint Q16_ONE       = 64'sd1 <<< GAIN_FRAC_BITS_DEF;
   localparam int     CODE_MAX      = (1 << FIELD_W) - 1;
   localparam int     SETTLE_CYCLES = 24;
   localparam int     LIMIT_CYCLES  = 300000;
   localparam int     HOLD_CYCLES   = 300;
   localparam int     HOLD_AT       = 30;      // results seen before the long hold-off

   localparam logic signed [GAIN_W-1:0] GAIN_MAX = 24'sh7FFFFF;
   localparam logic signed [GAIN_W-1:0] GAIN_MIN = 24'sh800000;

   typedef struct {
      logic [DUTY_W-1:0] duty;
      logic [CT_W-1:0]   curr_target;
   } loop_output_type;

   // Cascaded loop state and the queue of outputs still owed by the core.
   class duty_tracker;
      logic signed [GAIN_W-1:0]  volt_kp, volt_ki, curr_kp, curr_ki;
      logic signed [INTEG_W-1:0] volt_acc, curr_acc;
      loop_output_type           owed[$];
      logic [CT_W-1:0]           last_ct;
      int                        errors;

      function new();
         volt_kp  = VOLT_PROP_RST;
         volt_ki  = VOLT_INTEG_RST;
         curr_kp  = CURR_PROP_RST;
         curr_ki  = CURR_INTEG_RST;
         volt_acc = '0;
         curr_acc = '0;
         last_ct  = '0;
         errors   = 0;
      endfunction

      function void set_gain(csr_reg_type idx, logic signed [GAIN_W-1:0] val);
         case (idx)
            CSR_VOLT_PROP:  volt_kp = val;
            CSR_VOLT_INTEG: volt_ki = val;
            CSR_CURR_PROP:  curr_kp = val;
            CSR_CURR_INTEG: curr_ki = val;
            default: ;
         endcase
      endfunction

      // one PI stage: saturating integrator, output clamped to [0, 1.0] in Q16
      function longint pi_step(longint err, longint kp, longint ki,
                               inout logic signed [INTEG_W-1:0] acc);
         longint prop, total, integ;
         prop  = kp * err;
         total = longint'(acc) + ki * err;
         if (total > ACC_MAX) total = ACC_MAX;
         else if (total < ACC_MIN) total = ACC_MIN;
         acc   = total[INTEG_W-1:0];
         integ = total;
         if (integ > SUM_LIMIT) integ = SUM_LIMIT;
         else if (integ < -SUM_LIMIT) integ = -SUM_LIMIT;
         total = prop + integ;
         if (total > Q16_ONE) total = Q16_ONE;
         else if (total < 0) total = 0;
         // gains carry 16 fraction bits, so the stage output is already Q0.16
         return total;
      endfunction

      function void take_period(logic [FIELD_W-1:0] vt, logic [FIELD_W-1:0] vs,
                                logic [FIELD_W-1:0] cs);
         longint          frac, iref, duty;
         loop_output_type o;
         frac = pi_step(longint'(vt) - longint'(vs), volt_kp, volt_ki, volt_acc);
         iref = ((frac <<< SAMPLE_BITS_DEF) + (64'sd1 <<< 15)) >>> 16;
         duty = pi_step(iref - longint'(cs), curr_kp, curr_ki, curr_acc);
         o.duty        = duty[DUTY_W-1:0];
         o.curr_target = iref[CT_W-1:0];
         owed.push_back(o);
         last_ct = o.curr_target;
      endfunction

      function void check_result(logic [DUTY_W-1:0] duty, logic [CT_W-1:0] ct);
         loop_output_type o;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result, duty %0d curr_target %0d", $time, duty, ct);
            errors++;
            return;
         end
         o = owed.pop_front();
         if (duty !== o.duty) begin
            $display("%0t: duty expected %0d actual %0d", $time, o.duty, duty);
            errors++;
         end
         if (ct !== o.curr_target) begin
            $display("%0t: curr_target expected %0d actual %0d", $time, o.curr_target, ct);
            errors++;
         end
      endfunction

      function int outstanding();
         return owed.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   cpvc_req_if req_ch ();
   cpvc_rsp_if rsp_ch ();
   cpvc_csr_if csr_ch ();

   cascaded_pi_voltage_current_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   duty_tracker tracker = new();

   int tx_idle_pct  = 13;   // chance in a hundred that the sender skips a cycle
   int rx_idle_pct  = 74;   // same for the receiver
   int results_seen = 0;
   int hold_left    = 0;
   bit hold_done    = 1'b0;
   int cycle_count  = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a stuck handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Result side. Samples the handshake of the cycle just ended, then picks
   // the next ready. Once, after a few results, ready stays low for a long
   // stretch so that the core backs up and stops taking new items.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_result(rsp_ch.duty, rsp_ch.curr_target);
            results_seen++;
         end
         if (!hold_done && results_seen == HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   function automatic int clip_code(int v);
      if (v < 0) return 0;
      if (v > CODE_MAX) return CODE_MAX;
      return v;
   endfunction

   // Offer one control period; returns once the core has taken it. Valid is
   // left high so that back-to-back items need no extra cycle.
   task automatic send_period(int vt, int vs, int cs);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.volt_target <= vt[FIELD_W-1:0];
      req_ch.volt_sample <= vs[FIELD_W-1:0];
      req_ch.curr_sample <= cs[FIELD_W-1:0];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.take_period(vt[FIELD_W-1:0], vs[FIELD_W-1:0], cs[FIELD_W-1:0]);
   endtask

   // Mostly a converter near regulation: measured voltage close to the
   // reference and current close to the last reference; the rest is noise.
   task automatic send_random(int spread);
      int vt, vs, cs;
      if ($urandom_range(99) < 15) begin
         vt = $urandom_range(CODE_MAX);
         vs = $urandom_range(CODE_MAX);
         cs = $urandom_range(CODE_MAX);
      end else begin
         vt = $urandom_range(CODE_MAX);
         vs = clip_code(vt + $urandom_range(2 * spread) - spread);
         cs = clip_code(int'(tracker.last_ct) + $urandom_range(2 * spread) - spread);
      end
      send_period(vt, vs, cs);
   endtask

   // Drop valid, let every owed result arrive, then let the core settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gain(csr_reg_type idx, logic signed [GAIN_W-1:0] val);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wdata     <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      tracker.set_gain(idx, val);
      @(posedge clock);
   endtask

   task automatic write_small_gains();
      write_gain(CSR_VOLT_PROP,  24'($signed($urandom_range(8192)) - 4096));
      write_gain(CSR_VOLT_INTEG, 24'($signed($urandom_range(1024)) - 512));
      write_gain(CSR_CURR_PROP,  24'($signed($urandom_range(8192)) - 4096));
      write_gain(CSR_CURR_INTEG, 24'($signed($urandom_range(1024)) - 512));
   endtask

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.volt_target <= '0;
      req_ch.volt_sample <= '0;
      req_ch.curr_sample <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.reg_index   <= CSR_VOLT_PROP;
      csr_ch.wdata       <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default gains. Field extremes, equal and crossed voltages, current
      // above and below the reference, off-by-one errors around zero.
      tx_idle_pct = 13;
      rx_idle_pct = 74;
      send_period(0, 0, 0);
      send_period(CODE_MAX, CODE_MAX, CODE_MAX);
      send_period(CODE_MAX, 0, 0);
      send_period(0, CODE_MAX, CODE_MAX);
      send_period(0, CODE_MAX, 0);
      send_period(CODE_MAX, 0, CODE_MAX);
      send_period(512, 511, 0);
      send_period(511, 512, 512);
      send_period(512, 513, CODE_MAX);
      send_period(700, 702, 400);
      send_period(700, 699, 1);
      send_period(100, 101, 650);
      send_period(341, 682, 85);
      send_period(682, 341, 938);
      // random periods; the long receiver hold-off falls in here
      repeat (120) send_random(8);
      drain();

      // Extreme gains, both signs. Drive the voltage error hard one way long
      // enough to pin both integrators at their limits, then the other way
      // until they cross zero and saturate at the opposite limit.
      tx_idle_pct = 74;
      rx_idle_pct = 13;
      write_gain(CSR_VOLT_PROP,  GAIN_MIN);
      write_gain(CSR_VOLT_INTEG, GAIN_MAX);
      write_gain(CSR_CURR_PROP,  GAIN_MAX);
      write_gain(CSR_CURR_INTEG, GAIN_MIN);
      repeat (70) send_period(CODE_MAX - $urandom_range(3), $urandom_range(3),
                              $urandom_range(CODE_MAX));
      repeat (140) send_period($urandom_range(3), CODE_MAX - $urandom_range(3),
                               $urandom_range(CODE_MAX));
      drain();

      // Small gains keep both loops out of their clamps most of the time.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_small_gains();
      repeat (90) send_random(40);
      drain();
      write_small_gains();
      repeat (90) send_random(40);
      drain();

      if (tracker.errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
